// ===== hw/rtl/kwm_pkg.sv =====
package kwm_pkg;

    localparam int DEFAULT_RUNS      = 8;
    localparam int DEFAULT_RUN_DEPTH = 16;

    localparam int VAL_W    = 32;
    localparam int RUN_IN_W = 3;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] RUNS_IN_USE_RESET = 4'd8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_RUN = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_run_ctl;

    typedef struct packed {
        logic nonempty;
        logic full;
    } t_run_stat;

endpackage

// ===== hw/rtl/kwm_run_fifo.sv =====
module kwm_run_fifo #(
    parameter int DEPTH = kwm_pkg::DEFAULT_RUN_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kwm_pkg::t_run_ctl          i_ctl,
    input  logic [kwm_pkg::VAL_W-1:0]  i_data,
    output kwm_pkg::t_run_stat         o_stat,
    output logic [kwm_pkg::VAL_W-1:0]  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [kwm_pkg::VAL_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]          r_rptr;
    logic [PTR_W-1:0]          n_rptr;
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          n_fill;
    logic [kwm_pkg::VAL_W-1:0] r_q;
    logic                      r_byp;
    logic [kwm_pkg::VAL_W-1:0] r_byp_data;
    logic [SUM_W-1:0]          slot_sum;
    logic [PTR_W-1:0]          wslot;

    // tail slot: head plus fill, wrapped once
    always_comb begin
        slot_sum = SUM_W'(r_rptr) + SUM_W'(r_fill);
        if (slot_sum >= SUM_W'(DEPTH)) begin
            wslot = PTR_W'(slot_sum - SUM_W'(DEPTH));
        end else begin
            wslot = PTR_W'(slot_sum);
        end
    end

    always_comb begin
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_ctl.pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            n_fill = r_fill - 1'b1;
        end else if (i_ctl.push) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr <= '0;
            r_fill <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_rptr <= n_rptr;
            r_fill <= n_fill;
            // a write landing on the next head slot is forwarded past the memory
            r_byp  <= i_ctl.push && (wslot == n_rptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[wslot] <= i_data;
        end
        r_q        <= mem[n_rptr];
        r_byp_data <= i_data;
    end

    assign o_head          = r_byp ? r_byp_data : r_q;
    assign o_stat.nonempty = (r_fill != '0);
    assign o_stat.full     = (r_fill == CNT_W'(DEPTH));

endmodule

// ===== hw/rtl/kwm_min_tree.sv =====
module kwm_min_tree #(
    parameter int RUNS = kwm_pkg::DEFAULT_RUNS
) (
    input  logic [RUNS-1:0]                    i_valid,
    input  logic signed [kwm_pkg::VAL_W-1:0]   i_value [RUNS],
    output logic                               o_found,
    output logic [$clog2(RUNS)-1:0]            o_idx,
    output logic signed [kwm_pkg::VAL_W-1:0]   o_value
);

    localparam int IDX_W = $clog2(RUNS);
    localparam int LVL   = $clog2(RUNS);
    localparam int LEAVES = 1 << LVL;

    logic                             nd_v [LVL+1][LEAVES];
    logic [IDX_W-1:0]                 nd_i [LVL+1][LEAVES];
    logic signed [kwm_pkg::VAL_W-1:0] nd_d [LVL+1][LEAVES];

    // stable two-way picks: the left (lower index) side wins ties
    always_comb begin
        for (int l = 0; l <= LVL; l++) begin
            for (int n = 0; n < LEAVES; n++) begin
                nd_v[l][n] = 1'b0;
                nd_i[l][n] = '0;
                nd_d[l][n] = '0;
            end
        end
        for (int n = 0; n < RUNS; n++) begin
            nd_v[0][n] = i_valid[n];
            nd_i[0][n] = IDX_W'(n);
            nd_d[0][n] = i_value[n];
        end
        for (int l = 1; l <= LVL; l++) begin
            for (int n = 0; n < (LEAVES >> l); n++) begin
                if (nd_v[l-1][2*n+1] &&
                    (!nd_v[l-1][2*n] || (nd_d[l-1][2*n+1] < nd_d[l-1][2*n]))) begin
                    nd_v[l][n] = 1'b1;
                    nd_i[l][n] = nd_i[l-1][2*n+1];
                    nd_d[l][n] = nd_d[l-1][2*n+1];
                end else begin
                    nd_v[l][n] = nd_v[l-1][2*n];
                    nd_i[l][n] = nd_i[l-1][2*n];
                    nd_d[l][n] = nd_d[l-1][2*n];
                end
            end
        end
    end

    assign o_found = nd_v[LVL][0];
    assign o_idx   = nd_i[LVL][0];
    assign o_value = nd_d[LVL][0];

endmodule

// ===== hw/rtl/kway_sorted_run_merge.sv =====
// k-way merge of first-in-first-out runs of signed 32-bit values.
// input channel (i_in_valid / o_in_ready) carries one item per transfer:
//   i_op load appends i_value to run i_run_index, pop removes the smallest
//   head among the runs in use, lowest run index on ties.
// output channel (o_out_valid / i_out_ready) returns one result per item:
//   o_merged_value (popped value, else zero) and o_status (ok, all empty,
//   run full, bad run index). dropped loads leave the runs untouched.
// i_cfg_we / i_cfg_wdata write the runs-in-use register (0 acts as 1,
//   above RUNS acts as RUNS); write it only while the block is idle.
// pipeline: an item waits in the input register until it advances, and its
//   result is then registered in the output register. one item per cycle
//   is sustained while the receiver takes results: every run keeps its head
//   in a register fed by that run's memory read port, and a comparator tree
//   over all heads picks the winner in the same cycle.
// a stalled receiver holds the result; one more item waits in the input
//   register, then o_in_ready drops until the result is taken.
// reset (synchronous, active low) empties every run and sets runs in use
//   to 8; no clearing pass is needed.
module kway_sorted_run_merge #(
    parameter int RUNS      = kwm_pkg::DEFAULT_RUNS,
    parameter int RUN_DEPTH = kwm_pkg::DEFAULT_RUN_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [kwm_pkg::RUN_IN_W-1:0]       i_run_index,
    input  logic signed [kwm_pkg::VAL_W-1:0]   i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [kwm_pkg::VAL_W-1:0]   o_merged_value,
    output logic [1:0]                         o_status,
    input  logic                               i_cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int IDX_W = $clog2(RUNS);

    logic [kwm_pkg::CFG_W-1:0]          r_riu;
    logic                               r_in_vld;
    logic                               r_op;
    logic [kwm_pkg::RUN_IN_W-1:0]       r_idx;
    logic signed [kwm_pkg::VAL_W-1:0]   r_val;
    logic                               r_out_vld;
    logic signed [kwm_pkg::VAL_W-1:0]   r_mv;
    kwm_pkg::t_status                   r_st;
    logic signed [kwm_pkg::VAL_W-1:0]   n_mv;
    kwm_pkg::t_status                   n_st;

    logic                               adv;
    logic [RUNS-1:0]                    in_use;
    logic [RUNS-1:0]                    cand;
    logic [RUNS-1:0]                    push_vec;
    logic [RUNS-1:0]                    pop_vec;
    logic [RUNS-1:0]                    full_vec;
    logic                               idx_ok;
    logic                               sel_full;
    logic                               load_ok;
    logic                               do_pop;
    logic                               found;
    logic [IDX_W-1:0]                   win_idx;
    logic signed [kwm_pkg::VAL_W-1:0]   win_val;

    kwm_pkg::t_run_ctl                  ctl  [RUNS];
    kwm_pkg::t_run_stat                 stat [RUNS];
    logic signed [kwm_pkg::VAL_W-1:0]   head [RUNS];

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_riu     <= kwm_pkg::RUNS_IN_USE_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_riu <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op  <= i_op;
            r_idx <= i_run_index;
            r_val <= i_value;
        end
        if (adv) begin
            r_mv <= n_mv;
            r_st <= n_st;
        end
    end

    // run 0 always takes part, so a zero register behaves as one run
    always_comb begin
        for (int i = 0; i < RUNS; i++) begin
            in_use[i] = (i == 0) || (5'(i) < {1'b0, r_riu});
        end
    end

    assign idx_ok = ({29'd0, r_idx} < 32'(RUNS)) &&
                    ((r_idx == '0) || ({1'b0, r_idx} < r_riu));

    always_comb begin
        for (int i = 0; i < RUNS; i++) begin
            full_vec[i] = stat[i].full;
            cand[i]     = stat[i].nonempty && in_use[i];
        end
    end

    always_comb begin
        sel_full = 1'b0;
        for (int i = 0; i < RUNS; i++) begin
            if ({29'd0, r_idx} == 32'(i)) begin
                sel_full = full_vec[i];
            end
        end
    end

    assign load_ok = adv && (r_op == kwm_pkg::OP_LOAD) && idx_ok && !sel_full;
    assign do_pop  = adv && (r_op == kwm_pkg::OP_POP) && found;

    always_comb begin
        for (int i = 0; i < RUNS; i++) begin
            push_vec[i] = load_ok && ({29'd0, r_idx} == 32'(i));
            pop_vec[i]  = do_pop && (win_idx == IDX_W'(i));
        end
    end

    always_comb begin
        n_mv = '0;
        n_st = kwm_pkg::ST_OK;
        if (r_op == kwm_pkg::OP_LOAD) begin
            if (!idx_ok) begin
                n_st = kwm_pkg::ST_BAD_RUN;
            end else if (sel_full) begin
                n_st = kwm_pkg::ST_FULL;
            end
        end else if (!found) begin
            n_st = kwm_pkg::ST_EMPTY;
        end else begin
            n_mv = win_val;
        end
    end

    for (genvar g = 0; g < RUNS; g++) begin : g_run
        assign ctl[g].push = push_vec[g];
        assign ctl[g].pop  = pop_vec[g];

        kwm_run_fifo #(
            .DEPTH (RUN_DEPTH)
        ) u_fifo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_data  (r_val),
            .o_stat  (stat[g]),
            .o_head  (head[g])
        );
    end

    kwm_min_tree #(
        .RUNS (RUNS)
    ) u_tree (
        .i_valid (cand),
        .i_value (head),
        .o_found (found),
        .o_idx   (win_idx),
        .o_value (win_val)
    );

    assign o_out_valid    = r_out_vld;
    assign o_merged_value = r_mv;
    assign o_status       = r_st;

    // at most one run changes per item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(push_vec | pop_vec))
        else $error("more than one run updated in one cycle");

    // a pop that finds data removes exactly one head
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_op == kwm_pkg::OP_POP) && found) |-> $onehot(pop_vec))
        else $error("pop did not remove exactly one head");

    // a waiting item is not lost while the output stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> r_in_vld)
        else $error("stalled item dropped from input register");

    // every processed item yields a result in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("processed item produced no result");

    // a load never pushes into a run outside the ones in use
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((push_vec & ~in_use) == '0))
        else $error("load pushed into a run not in use");

endmodule
